FILE: rtl/core/lobn_pkg.sv
// Shared types and constants for the open-boundary lattice neighbour lister.
// No dependencies; every other file in rtl/core imports this package.
package lobn_pkg;

   localparam int LEN_W  = 11;
   localparam int DIM_W  = 3;
   localparam int QB_W   = 4;
   localparam int NDIM_W = 2;
   localparam int POW_W  = 35;
   localparam int CSR_W  = 1;

   localparam logic [POW_W-1:0] POW_CAP = 35'h4_0000_0000;

   localparam logic [CSR_W-1:0] CSR_SIDE_LENGTH = 1'b0;
   localparam logic [CSR_W-1:0] CSR_DIMENSIONS  = 1'b1;

   typedef struct packed {
      logic             busy;
      logic [LEN_W-1:0] side_m1;
      logic [QB_W-1:0]  qbits;
      logic [DIM_W-1:0] dims;
   } cfg_type;

   typedef enum logic [1:0] {
      FE_IDLE,
      FE_DIV,
      FE_PUSH
   } fe_state_type;

endpackage

FILE: rtl/core/lobn_cfg.sv
// Configuration registers and the power table L^j built by a multiply sequencer.
// Depends on lobn_pkg.
module lobn_cfg
   import lobn_pkg::*;
#(
   parameter int MAX_DIMS = 4
)
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write,
   input  logic [CSR_W-1:0]              csr_index,
   input  logic [LEN_W-1:0]              csr_data,
   output cfg_type                       cfg,
   output logic [MAX_DIMS:0][POW_W-1:0]  pow
);

   localparam int CW     = $clog2(MAX_DIMS + 1);
   localparam int PROD_W = POW_W + LEN_W;

   logic [LEN_W-1:0]               side_ff, side_in;
   logic [DIM_W-1:0]               dims_ff, dims_in;
   logic                           busy_ff, busy_in;
   logic [CW-1:0]                  cnt_ff, cnt_in;
   logic [POW_W-1:0]               acc_ff, acc_in;
   logic [MAX_DIMS:1][POW_W-1:0]   pow_ff, pow_in;

   logic [LEN_W-1:0]  leff;
   logic [LEN_W-1:0]  lm1;
   logic [QB_W-1:0]   qbits;
   logic [DIM_W-1:0]  dims_eff;
   logic [PROD_W-1:0] prod;
   logic [POW_W-1:0]  nxt;

   always_comb begin
      leff = (side_ff < LEN_W'(2)) ? LEN_W'(2) : side_ff;
      lm1  = leff - LEN_W'(1);
      qbits = '0;
      for (int k = 0; k < LEN_W; k++) begin
         if (lm1[k]) begin
            qbits = QB_W'(k + 1);
         end
      end
      if (dims_ff == '0) begin
         dims_eff = DIM_W'(1);
      end else if (int'(dims_ff) > MAX_DIMS) begin
         dims_eff = DIM_W'(MAX_DIMS);
      end else begin
         dims_eff = dims_ff;
      end
   end

   always_comb begin
      prod = acc_ff * leff;
      nxt  = (prod > PROD_W'(POW_CAP)) ? POW_CAP : prod[POW_W-1:0];
   end

   always_comb begin
      side_in = side_ff;
      dims_in = dims_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_SIDE_LENGTH: side_in = csr_data;
            CSR_DIMENSIONS:  dims_in = csr_data[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   // rebuild the table after every write
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      pow_in  = pow_ff;
      if (csr_write) begin
         busy_in = 1'b1;
         cnt_in  = CW'(1);
         acc_in  = POW_W'(1);
      end else if (busy_ff) begin
         acc_in = nxt;
         cnt_in = cnt_ff + CW'(1);
         for (int k = 1; k <= MAX_DIMS; k++) begin
            if (cnt_ff == CW'(k)) begin
               pow_in[k] = nxt;
            end
         end
         if (cnt_ff == CW'(MAX_DIMS)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= LEN_W'(2);
         dims_ff <= DIM_W'(1);
         busy_ff <= 1'b1;
         cnt_ff  <= CW'(1);
         acc_ff  <= POW_W'(1);
      end else begin
         side_ff <= side_in;
         dims_ff <= dims_in;
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         acc_ff  <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      pow_ff <= pow_in;
   end

   assign pow = {pow_ff, POW_W'(1)};

   assign cfg.busy    = busy_ff;
   assign cfg.side_m1 = lm1;
   assign cfg.qbits   = qbits;
   assign cfg.dims    = dims_eff;

endmodule

FILE: rtl/core/lobn_front.sv
// Front end: takes site beats, checks range and extracts base-L digits one
// quotient bit per cycle, then hands a neighbour mask on. Depends on lobn_pkg.
module lobn_front
   import lobn_pkg::*;
#(
   parameter int MAX_DIMS        = 4,
   parameter int SITE_INDEX_BITS = 20
)
(
   input  logic                          clock,
   input  logic                          reset,
   input  cfg_type                       cfg,
   input  logic [MAX_DIMS:0][POW_W-1:0]  pow,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [SITE_INDEX_BITS-1:0]    req_site_index,
   output logic                          job_push,
   input  logic                          job_full,
   output logic [SITE_INDEX_BITS-1:0]    job_site,
   output logic                          job_err,
   output logic                          job_bnd,
   output logic [2*MAX_DIMS-1:0]         job_pend
);

   localparam int SIB = SITE_INDEX_BITS;
   localparam int JW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int DW  = SIB + LEN_W;
   localparam int PM  = 2 * MAX_DIMS;

   fe_state_type state_ff, state_in;

   logic [SIB-1:0]   site_ff, site_in;
   logic [SIB-1:0]   rem_ff, rem_in;
   logic [DW-1:0]    d_ff, d_in;
   logic [LEN_W-1:0] q_ff, q_in;
   logic [QB_W-1:0]  b_ff, b_in;
   logic [JW-1:0]    j_ff, j_in;
   logic [PM-1:0]    pend_ff, pend_in;
   logic             bnd_ff, bnd_in;
   logic             err_ff, err_in;

   logic             accept;
   logic             err_now;
   logic [JW-1:0]    j_sel;
   logic [POW_W-1:0] pow_sel;
   logic [POW_W-1:0] total;
   logic [SIB:0]     cap_val;
   logic [DW-1:0]    d_load;
   logic             ge;
   logic [LEN_W-1:0] q_step;
   logic [SIB-1:0]   rem_step;
   logic             has_lo;
   logic             has_hi;

   always_comb begin
      j_sel = (state_ff == FE_DIV) ? j_ff - JW'(1) : JW'(cfg.dims - DIM_W'(1));
      pow_sel = '0;
      for (int k = 0; k < MAX_DIMS; k++) begin
         if (j_sel == JW'(k)) begin
            pow_sel = pow[k];
         end
      end
      total = '0;
      for (int k = 1; k <= MAX_DIMS; k++) begin
         if (cfg.dims == DIM_W'(k)) begin
            total = pow[k];
         end
      end
      err_now = POW_W'(req_site_index) >= total;
      cap_val = (|pow_sel[POW_W-1:SIB]) ? {1'b1, {SIB{1'b0}}} : {1'b0, pow_sel[SIB-1:0]};
      d_load  = DW'(cap_val) << (cfg.qbits - QB_W'(1));
      ge       = DW'(rem_ff) >= d_ff;
      q_step   = {q_ff[LEN_W-2:0], ge};
      rem_step = ge ? rem_ff - d_ff[SIB-1:0] : rem_ff;
      has_lo   = q_step != '0;
      has_hi   = q_step != cfg.side_m1;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FE_IDLE: begin
            if (accept) state_in = err_now ? FE_PUSH : FE_DIV;
         end
         FE_DIV: begin
            if (b_ff == '0 && j_ff == '0) state_in = FE_PUSH;
         end
         FE_PUSH: begin
            if (accept) begin
               state_in = err_now ? FE_PUSH : FE_DIV;
            end else if (!job_full) begin
               state_in = FE_IDLE;
            end
         end
         default: state_in = FE_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      job_push  = 1'b0;
      unique case (state_ff)
         FE_IDLE: req_stall = cfg.busy;
         FE_DIV:  req_stall = 1'b1;
         FE_PUSH: begin
            job_push  = !job_full;
            req_stall = cfg.busy || job_full;
         end
         default: req_stall = 1'b1;
      endcase
   end

   assign accept = req_valid && !req_stall;

   always_comb begin
      site_in = site_ff;
      rem_in  = rem_ff;
      d_in    = d_ff;
      q_in    = q_ff;
      b_in    = b_ff;
      j_in    = j_ff;
      pend_in = pend_ff;
      bnd_in  = bnd_ff;
      err_in  = err_ff;
      if (accept) begin
         site_in = req_site_index;
         rem_in  = req_site_index;
         err_in  = err_now;
         pend_in = '0;
         bnd_in  = 1'b0;
         q_in    = '0;
         b_in    = cfg.qbits - QB_W'(1);
         j_in    = j_sel;
         d_in    = d_load;
      end else if (state_ff == FE_DIV) begin
         rem_in = rem_step;
         q_in   = q_step;
         if (b_ff == '0) begin
            for (int k = 0; k < MAX_DIMS; k++) begin
               if (j_ff == JW'(k)) begin
                  pend_in[2*k]   = has_lo;
                  pend_in[2*k+1] = has_hi;
               end
            end
            bnd_in = bnd_ff || !has_lo || !has_hi;
            // next dimension down
            j_in = j_ff - JW'(1);
            d_in = d_load;
            b_in = cfg.qbits - QB_W'(1);
            q_in = '0;
         end else begin
            b_in = b_ff - QB_W'(1);
            d_in = d_ff >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      site_ff <= site_in;
      rem_ff  <= rem_in;
      d_ff    <= d_in;
      q_ff    <= q_in;
      b_ff    <= b_in;
      j_ff    <= j_in;
      pend_ff <= pend_in;
      bnd_ff  <= bnd_in;
      err_ff  <= err_in;
   end

   assign job_site = site_ff;
   assign job_err  = err_ff;
   assign job_bnd  = bnd_ff;
   assign job_pend = pend_ff;

endmodule

FILE: rtl/core/lobn_fifo.sv
// Small register queue between the front end and the back end.
// Depends on lobn_pkg.
module lobn_fifo
   import lobn_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      cnt_ff, cnt_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + (AW+1)'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - (AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = mem_ff[rd_ptr_ff];
   assign full     = cnt_ff == (AW+1)'(DEPTH);
   assign empty    = cnt_ff == '0;

endmodule

FILE: rtl/core/lobn_back.sv
// Back end: walks the neighbour mask lowest bit first and drives one result
// beat per cycle unless rsp_stall holds the output register. Depends on lobn_pkg.
module lobn_back
   import lobn_pkg::*;
#(
   parameter int MAX_DIMS        = 4,
   parameter int SITE_INDEX_BITS = 20
)
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic [MAX_DIMS:0][POW_W-1:0]  pow,
   input  logic                          job_valid,
   output logic                          job_pop,
   input  logic [SITE_INDEX_BITS-1:0]    job_site,
   input  logic                          job_err,
   input  logic                          job_bnd,
   input  logic [2*MAX_DIMS-1:0]         job_pend,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [SITE_INDEX_BITS-1:0]    rsp_neighbor_index,
   output logic [NDIM_W-1:0]             rsp_neighbor_dimension,
   output logic                          rsp_neighbor_upper,
   output logic                          rsp_site_on_boundary,
   output logic                          rsp_index_error,
   output logic                          rsp_last
);

   localparam int SIB = SITE_INDEX_BITS;
   localparam int PM  = 2 * MAX_DIMS;

   logic           act_ff, act_in;
   logic [PM-1:0]  pend_ff, pend_in;
   logic [SIB-1:0] site_ff, site_in;
   logic           bnd_ff, bnd_in;
   logic           err_ff, err_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [SIB-1:0]    idx_ff, idx_in;
   logic [NDIM_W-1:0] dim_ff, dim_in;
   logic              up_ff, up_in;
   logic              obnd_ff, obnd_in;
   logic              oerr_ff, oerr_in;
   logic              last_ff, last_in;

   logic              out_free;
   logic              emit;
   logic [PM-1:0]     low;
   logic [PM-1:0]     rest;
   logic              last_now;
   logic [SIB-1:0]    step;
   logic [NDIM_W-1:0] sel_dim;
   logic              sel_up;

   always_comb begin
      out_free = !rsp_valid_ff || !rsp_stall;
      emit     = act_ff && out_free;
      low      = pend_ff & (~pend_ff + PM'(1));
      rest     = pend_ff & ~low;
      last_now = err_ff || (rest == '0);
      job_pop  = job_valid && (!act_ff || (emit && last_now));
      step    = '0;
      sel_dim = '0;
      sel_up  = 1'b0;
      for (int k = 0; k < PM; k++) begin
         if (low[k]) begin
            step    = pow[k >> 1][SIB-1:0];
            sel_dim = NDIM_W'(k >> 1);
            sel_up  = (k % 2) == 1;
         end
      end
   end

   always_comb begin
      act_in  = act_ff;
      pend_in = pend_ff;
      site_in = site_ff;
      bnd_in  = bnd_ff;
      err_in  = err_ff;
      if (job_pop) begin
         act_in  = 1'b1;
         pend_in = job_pend;
         site_in = job_site;
         bnd_in  = job_bnd;
         err_in  = job_err;
      end else if (emit) begin
         pend_in = rest;
         if (last_now) act_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = out_free ? act_ff : rsp_valid_ff;
      idx_in  = idx_ff;
      dim_in  = dim_ff;
      up_in   = up_ff;
      obnd_in = obnd_ff;
      oerr_in = oerr_ff;
      last_in = last_ff;
      if (emit) begin
         oerr_in = err_ff;
         last_in = last_now;
         if (err_ff) begin
            idx_in  = '0;
            dim_in  = '0;
            up_in   = 1'b0;
            obnd_in = 1'b0;
         end else begin
            idx_in  = sel_up ? site_ff + step : site_ff - step;
            dim_in  = sel_dim;
            up_in   = sel_up;
            obnd_in = bnd_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         act_ff       <= act_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      site_ff <= site_in;
      bnd_ff  <= bnd_in;
      err_ff  <= err_in;
      idx_ff  <= idx_in;
      dim_ff  <= dim_in;
      up_ff   <= up_in;
      obnd_ff <= obnd_in;
      oerr_ff <= oerr_in;
      last_ff <= last_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_neighbor_index     = idx_ff;
   assign rsp_neighbor_dimension = dim_ff;
   assign rsp_neighbor_upper     = up_ff;
   assign rsp_site_on_boundary   = obnd_ff;
   assign rsp_index_error        = oerr_ff;
   assign rsp_last               = last_ff;

endmodule

FILE: rtl/core/lattice_open_boundary_neighbors.sv
// Top level of the open-boundary lattice neighbour lister.
// Depends on lobn_pkg, lobn_cfg, lobn_front, lobn_fifo and lobn_back.
//
//   port group | direction | beat carries
//   req_*      | in        | site_index
//   rsp_*      | out       | neighbour index, dimension, upper, boundary, error, last
//   csr_*      | in        | side_length (index 0), dimensions (index 1)
//
// Front end extracts one quotient bit per cycle in its compare-subtract unit, as
// many per dimension as L-1 has bits; an out-of-range site skips the division.
// Back end gives one result beat per cycle unless rsp_stall holds the output
// register: D to 2*D beats per site, one for an out-of-range site. The two
// overlap through a two-entry queue. After reset and after each csr write
// the power table is rebuilt by a multiplier; req_stall stays high meanwhile.
// rsp_stall also holds the back end; the front works on until the queue is full.
module lattice_open_boundary_neighbors
   import lobn_pkg::*;
#(
   parameter int MAX_DIMS        = 4,
   parameter int SITE_INDEX_BITS = 20
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write,
   input  logic [CSR_W-1:0]           csr_index,
   input  logic [LEN_W-1:0]           csr_data,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [SITE_INDEX_BITS-1:0] req_site_index,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [SITE_INDEX_BITS-1:0] rsp_neighbor_index,
   output logic [NDIM_W-1:0]          rsp_neighbor_dimension,
   output logic                       rsp_neighbor_upper,
   output logic                       rsp_site_on_boundary,
   output logic                       rsp_index_error,
   output logic                       rsp_last
);

   localparam int SIB = SITE_INDEX_BITS;
   localparam int PM  = 2 * MAX_DIMS;
   localparam int JOB_W = SIB + 2 + PM;

   cfg_type                       cfg;
   logic [MAX_DIMS:0][POW_W-1:0]  pow;

   logic             job_push;
   logic             job_full;
   logic             job_pop;
   logic             fifo_empty;
   logic [JOB_W-1:0] job_wdata;
   logic [JOB_W-1:0] job_rdata;

   logic [SIB-1:0]   f_site;
   logic             f_err;
   logic             f_bnd;
   logic [PM-1:0]    f_pend;
   logic [SIB-1:0]   b_site;
   logic             b_err;
   logic             b_bnd;
   logic [PM-1:0]    b_pend;

   lobn_cfg #(
      .MAX_DIMS (MAX_DIMS)
   ) u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg),
      .pow       (pow)
   );

   lobn_front #(
      .MAX_DIMS        (MAX_DIMS),
      .SITE_INDEX_BITS (SITE_INDEX_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .pow            (pow),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_site_index (req_site_index),
      .job_push       (job_push),
      .job_full       (job_full),
      .job_site       (f_site),
      .job_err        (f_err),
      .job_bnd        (f_bnd),
      .job_pend       (f_pend)
   );

   assign job_wdata = {f_site, f_err, f_bnd, f_pend};

   lobn_fifo #(
      .WIDTH (JOB_W),
      .DEPTH (2)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_wdata),
      .full      (job_full),
      .pop       (job_pop),
      .pop_data  (job_rdata),
      .empty     (fifo_empty)
   );

   assign {b_site, b_err, b_bnd, b_pend} = job_rdata;

   lobn_back #(
      .MAX_DIMS        (MAX_DIMS),
      .SITE_INDEX_BITS (SITE_INDEX_BITS)
   ) u_back (
      .clock                  (clock),
      .reset                  (reset),
      .pow                    (pow),
      .job_valid              (!fifo_empty),
      .job_pop                (job_pop),
      .job_site               (b_site),
      .job_err                (b_err),
      .job_bnd                (b_bnd),
      .job_pend               (b_pend),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_neighbor_index     (rsp_neighbor_index),
      .rsp_neighbor_dimension (rsp_neighbor_dimension),
      .rsp_neighbor_upper     (rsp_neighbor_upper),
      .rsp_site_on_boundary   (rsp_site_on_boundary),
      .rsp_index_error        (rsp_index_error),
      .rsp_last               (rsp_last)
   );

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      job_push |-> !job_full)
      else $error("queue written while full");

   a_pop_data: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> !fifo_empty)
      else $error("queue read while empty");

   a_busy_blocks: assert property (@(posedge clock) disable iff (reset)
      cfg.busy |-> req_stall)
      else $error("site taken while power table rebuilds");

   a_err_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_index_error) |-> (rsp_last && !rsp_site_on_boundary))
      else $error("range error beat not a lone final beat");

endmodule
